// ===== design/crc_pkg.sv =====
`default_nettype none

package crc_pkg;

    // widths of the fixed fields
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CRC_W   = 32;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned ORDER_W = 6;
    localparam int unsigned CFG_IDX_W = 3;

    // most data bits consumed from one beat
    localparam logic [COUNT_W-1:0] MAX_DATA_WIDTH = COUNT_W'(32);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_ORDER      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_XOR      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_RESULT = CFG_IDX_W'(4);

    // configuration reset values
    localparam logic [ORDER_W-1:0] RST_CRC_ORDER     = ORDER_W'(8);
    localparam logic [CRC_W-1:0]   RST_POLYNOMIAL    = CRC_W'(32'h8c);
    localparam logic [CRC_W-1:0]   RST_INITIAL_VALUE = '0;
    localparam logic [CRC_W-1:0]   RST_FINAL_XOR     = '0;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DONE
    } crc_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic emit;
    } crc_cmd_t;

endpackage

`default_nettype wire

// ===== design/configurable_reflected_crc.sv =====
`default_nettype none

// channel   direction  handshake                payload
// in        sink       in_valid / in_stall      data_bits, bit_count, first_item, last_item
// out       source     out_valid / out_stall    crc_value
// cfg       sink       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// an input beat is loaded, then shifted through the single-bit lfsr step once per data bit
// (bit_count clamped to 32), then finished; in_stall stays high until the beat is finished
// the result register holds one finished crc; a new input beat is taken while it waits
// a closing beat waits in the finish cycle while the result register is full and stalled
// async active-low reset restores the register defaults and clears the crc state
// cfg_ready is always high; configuration is applied on the accepting edge

module configurable_reflected_crc
    import crc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [DATA_W-1:0]    data_bits,
    input  wire logic [COUNT_W-1:0]   bit_count,
    input  wire logic                 first_item,
    input  wire logic                 last_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [CRC_W-1:0]          crc_value,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CRC_W-1:0]     cfg_data
);

    crc_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // sequencing of load, shift and finish
    crc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .bit_count (bit_count),
        .last_item (last_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // crc state, configuration and result
    crc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .data_bits  (data_bits),
        .first_item (first_item),
        .cmd        (cmd),
        .crc_value  (crc_value)
    );

endmodule

`default_nettype wire

// ===== design/crc_dp.sv =====
`default_nettype none

module crc_dp
    import crc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CRC_W-1:0]     cfg_data,
    input  wire logic [DATA_W-1:0]    data_bits,
    input  wire logic                 first_item,
    input  wire crc_cmd_t             cmd,
    output logic [CRC_W-1:0]          crc_value
);

    logic [ORDER_W-1:0] crc_order_reg;
    logic [CRC_W-1:0]   polynomial_reg;
    logic [CRC_W-1:0]   initial_value_reg;
    logic [CRC_W-1:0]   final_xor_reg;
    logic               reverse_result_reg;

    logic [CRC_W-1:0]   crc_reg;
    logic [CRC_W-1:0]   crc_next;
    logic [DATA_W-1:0]  data_reg;
    logic [DATA_W-1:0]  data_next;
    logic [CRC_W-1:0]   result_reg;

    logic [ORDER_W-1:0] eff_order;
    logic [CRC_W-1:0]   mask;
    logic [CRC_W-1:0]   masked;
    logic [CRC_W-1:0]   mirrored;
    logic [4:0]         mirror_shift;
    logic [CRC_W-1:0]   result_next;
    logic               feedback;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_order_reg      <= RST_CRC_ORDER;
            polynomial_reg     <= RST_POLYNOMIAL;
            initial_value_reg  <= RST_INITIAL_VALUE;
            final_xor_reg      <= RST_FINAL_XOR;
            reverse_result_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CRC_ORDER:      crc_order_reg      <= cfg_data[ORDER_W-1:0];
                CFG_POLYNOMIAL:     polynomial_reg     <= cfg_data;
                CFG_INITIAL_VALUE:  initial_value_reg  <= cfg_data;
                CFG_FINAL_XOR:      final_xor_reg      <= cfg_data;
                CFG_REVERSE_RESULT: reverse_result_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // order clamped to 1..32 and its mask
    always_comb
    begin
        if (crc_order_reg == '0)
            eff_order = ORDER_W'(1);
        else if (crc_order_reg > ORDER_W'(CRC_W))
            eff_order = ORDER_W'(CRC_W);
        else
            eff_order = crc_order_reg;

        if (eff_order == ORDER_W'(CRC_W))
            mask = '1;
        else
            mask = (CRC_W'(1) << eff_order[4:0]) - CRC_W'(1);
    end

    // load of a new beat, or one lfsr step, lsb first
    always_comb
    begin
        feedback  = crc_reg[0] ^ data_reg[0];
        crc_next  = crc_reg;
        data_next = data_reg;
        if (cmd.load)
        begin
            data_next = data_bits;
            if (first_item)
                crc_next = initial_value_reg & mask;
        end
        else if (cmd.shift)
        begin
            data_next = data_reg >> 1;
            crc_next  = (crc_reg >> 1) ^ (feedback ? polynomial_reg : '0);
        end
    end

    // finished value, low order bits mirrored on request
    always_comb
    begin
        masked = (crc_reg ^ final_xor_reg) & mask;
        for (int i = 0; i < CRC_W; i++)
            mirrored[i] = masked[CRC_W-1-i];
        mirror_shift = 5'(ORDER_W'(CRC_W) - eff_order);
        result_next  = reverse_result_reg ? (mirrored >> mirror_shift) : masked;
    end

    // crc state, reset to the masked reset initial value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= RST_INITIAL_VALUE & ((CRC_W'(1) << RST_CRC_ORDER) - CRC_W'(1));
        else
            crc_reg <= crc_next;
    end

    // data shifter and result register
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (cmd.emit)
            result_reg <= result_next;
    end

    assign crc_value = result_reg;

endmodule

`default_nettype wire

// ===== design/crc_ctrl.sv =====
`default_nettype none

module crc_ctrl
    import crc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [COUNT_W-1:0] bit_count,
    input  wire logic               last_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output crc_cmd_t                cmd
);

    crc_state_t         state_reg;
    crc_state_t         state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               last_reg;
    logic               last_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COUNT_W-1:0] count_clamped;
    logic               slot_free;

    assign count_clamped = (bit_count > MAX_DATA_WIDTH) ? MAX_DATA_WIDTH : bit_count;
    assign slot_free     = !out_valid_reg || !out_stall;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    count_next = count_clamped;
                    last_next  = last_item;
                    state_next = (count_clamped == '0) ? ST_DONE : ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                count_next = count_reg - COUNT_W'(1);
                if (count_reg == COUNT_W'(1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // checks
    a_shift_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && count_reg == COUNT_W'(1)) |=> state_reg == ST_DONE)
        else $error("shift did not end after last bit");

    a_shift_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT |-> count_reg != '0)
        else $error("shifting with no bits left");

    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && bit_count == '0) |=> state_reg == ST_DONE)
        else $error("empty item did not go straight to done");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted result not presented");

    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !last_reg) |=> !$rose(out_valid_reg))
        else $error("result from an item that does not close a message");

endmodule

`default_nettype wire
